// ===== rtl/kpl_pkg.sv =====
// shared constants, types and helpers for the keyword prefix lookup block
package kpl_pkg;

    // default table geometry
    localparam int ENTRIES_DEF   = 32;
    localparam int KEY_CHARS_DEF = 16;

    // fixed field widths
    localparam int CFG_W    = 6;
    localparam int ENTRY_W  = 5;
    localparam int POS_W    = 4;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 7;
    localparam int LENGTH_W = 5;

    // longest length that the result field can carry
    localparam int LENGTH_MAX = (1 << LENGTH_W) - 1;

    // request kinds
    typedef enum logic
    {
        REQ_LOAD   = 1'b0,
        REQ_SEARCH = 1'b1
    } req_kind_t;

    // ascii lowercase fold
    function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== rtl/keyword_prefix_lookup.sv =====
// keyword prefix lookup: table store, range scan sequencer and result register
//
// A load transaction (req_type 0) writes one table character.
// A search transaction (req_type 1) scans the live entry range from the top
// down, one table entry per cycle through the single read port of the keyword
// memory: the first read is issued when the character is accepted, the scan
// state compares entries, and the resolve state then settles the new range. The
// block takes no new transaction until the current character is settled; a
// waiting result only holds the block when a second result is ready before it
// is taken. The entry count written through cfg_data is sampled at the first
// character of every search and is clamped to ENTRIES. The keyword table has
// no reset; load every character of every live entry before searching.
module keyword_prefix_lookup
    import kpl_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int KEY_CHARS = KEY_CHARS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_we,
    input  logic [CFG_W-1:0]           cfg_data,

    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic                       req_type,
    input  logic [ENTRY_W-1:0]         entry_index,
    input  logic [POS_W-1:0]           char_position,
    input  logic [CHAR_W-1:0]          char_value,

    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output logic signed [INDEX_W-1:0]  match_index,
    output logic [LENGTH_W-1:0]        matched_length
);

    // derived widths
    localparam int IW    = $clog2(ENTRIES + 1) + 1;
    localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW    = $clog2(KEY_CHARS + 1);
    localparam int DEPTH = ENTRIES * KEY_CHARS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE
    } state_t;

    // keyword memory
    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              wr_en;

    // control registers
    state_t                  state_reg;
    logic [CFG_W-1:0]        entries_reg;
    logic signed [IW-1:0]    range_low_reg;
    logic signed [IW-1:0]    range_high_reg;
    logic signed [IW-1:0]    i_reg;
    logic signed [IW-1:0]    newend_reg;
    logic [PW-1:0]           pos_reg;
    logic                    finished_reg;
    logic                    rsp_valid_reg;

    // payload registers
    logic [CHAR_W-1:0]       lc_reg;
    logic                    zero_reg;
    logic signed [INDEX_W-1:0] index_reg;
    logic [LENGTH_W-1:0]     length_reg;

    // combinational helpers
    logic                    req_fire;
    logic signed [IW-1:0]    live;
    logic signed [IW-1:0]    start_low;
    logic signed [IW-1:0]    start_high;
    logic signed [IW-1:0]    i_dec;
    logic signed [IW-1:0]    rd_entry;
    logic [EW-1:0]           rd_ent;
    logic [PW-1:0]           rd_pos;
    logic [CHAR_W-1:0]       table_char;
    logic                    slot_free;
    logic                    rsp_load;
    logic [PW:0]             len_pos;
    logic [PW:0]             len_pos1;
    logic [LENGTH_W-1:0]     len_mis;
    logic [LENGTH_W-1:0]     len_hit;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    // a result is loaded when the character settles with a miss or on the terminator
    assign rsp_load  = (state_reg == ST_RESOLVE) && slot_free &&
                       ((newend_reg == i_reg) || zero_reg);

    assign rsp_valid      = rsp_valid_reg;
    assign match_index    = index_reg;
    assign matched_length = length_reg;

    // live entry count, clamped to the table size
    assign live = (int'(entries_reg) > ENTRIES) ? IW'(ENTRIES) : IW'(entries_reg);

    // range at the start of this character
    assign start_low  = (pos_reg == '0) ? IW'(-1) : range_low_reg;
    assign start_high = (pos_reg == '0) ? live - IW'(1) : range_high_reg;
    assign i_dec      = i_reg - IW'(1);

    // read address: first entry of the range on accept, next lower one while scanning
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            rd_entry = start_high;
        end
        else
        begin
            rd_entry = i_dec;
        end
        if (rd_entry < 0 || rd_entry >= IW'(ENTRIES))
        begin
            rd_ent = '0;
        end
        else
        begin
            rd_ent = EW'(rd_entry);
        end
        rd_pos  = (int'(pos_reg) < KEY_CHARS) ? pos_reg : '0;
        rd_addr = AW'(int'(rd_ent) * KEY_CHARS + int'(rd_pos));
    end

    // load address and range check
    assign wr_addr = AW'(int'(entry_index) * KEY_CHARS + int'(char_position));
    assign wr_en   = req_fire && (req_type == REQ_LOAD) &&
                     (int'(entry_index) < ENTRIES) && (int'(char_position) < KEY_CHARS);

    // table character at the search position, zero past the key width
    assign table_char = (int'(pos_reg) < KEY_CHARS) ? lower_ascii(rd_data_reg) : '0;

    // result lengths, saturated to the field
    assign len_pos  = {1'b0, pos_reg};
    assign len_pos1 = len_pos + (PW+1)'(1);
    assign len_mis  = (int'(len_pos) > LENGTH_MAX) ? LENGTH_W'(LENGTH_MAX) : LENGTH_W'(len_pos);
    assign len_hit  = (int'(len_pos1) > LENGTH_MAX) ? LENGTH_W'(LENGTH_MAX) : LENGTH_W'(len_pos1);

    // keyword memory: one write port for loads, one registered read port for the scan
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= char_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
        end
        else if (cfg_we)
        begin
            entries_reg <= cfg_data;
        end
    end

    // search sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            range_low_reg  <= IW'(-1);
            range_high_reg <= IW'(-1);
            i_reg          <= IW'(-1);
            newend_reg     <= IW'(-1);
            pos_reg        <= '0;
            finished_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            lc_reg         <= '0;
            zero_reg       <= 1'b0;
            index_reg      <= '0;
            length_reg     <= '0;
        end
        else
        begin
            // result valid: set on a new result, cleared when taken
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire && req_type == REQ_SEARCH)
                    begin
                        if (finished_reg)
                        begin
                            // drop characters until the terminating zero
                            if (char_value == '0)
                            begin
                                finished_reg <= 1'b0;
                                pos_reg      <= '0;
                            end
                        end
                        else
                        begin
                            lc_reg         <= lower_ascii(char_value);
                            zero_reg       <= (char_value == '0);
                            range_low_reg  <= start_low;
                            range_high_reg <= start_high;
                            i_reg          <= start_high;
                            newend_reg     <= start_high;
                            if (start_high > start_low)
                            begin
                                state_reg <= ST_SCAN;
                            end
                            else
                            begin
                                state_reg <= ST_RESOLVE;
                            end
                        end
                    end
                end

                ST_SCAN:
                begin
                    // one entry compare per cycle
                    if (lc_reg > table_char)
                    begin
                        state_reg <= ST_RESOLVE;
                    end
                    else
                    begin
                        if (lc_reg < table_char)
                        begin
                            newend_reg <= newend_reg - IW'(1);
                        end
                        i_reg <= i_dec;
                        if (!(i_dec > range_low_reg))
                        begin
                            state_reg <= ST_RESOLVE;
                        end
                    end
                end

                ST_RESOLVE:
                begin
                    if (newend_reg == i_reg)
                    begin
                        // nothing matched at this position
                        if (slot_free)
                        begin
                            if (range_high_reg > range_low_reg + IW'(1))
                            begin
                                index_reg <= INDEX_W'(IW'(-1));
                            end
                            else
                            begin
                                index_reg <= INDEX_W'(i_reg + IW'(1));
                            end
                            length_reg    <= len_mis;
                            finished_reg  <= !zero_reg;
                            pos_reg       <= '0;
                            state_reg     <= ST_IDLE;
                        end
                    end
                    else if (zero_reg)
                    begin
                        // end of string with a live range
                        if (slot_free)
                        begin
                            range_high_reg <= newend_reg;
                            range_low_reg  <= i_reg;
                            index_reg      <= INDEX_W'(i_reg + IW'(1));
                            length_reg     <= len_hit;
                            pos_reg        <= '0;
                            state_reg      <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        // narrow the range and move to the next position
                        range_high_reg <= newend_reg;
                        range_low_reg  <= i_reg;
                        pos_reg        <= pos_reg + PW'(1);
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
